// ----- src/tws_pkg.sv -----
`timescale 1ns / 1ps
// Package for the three-wire 9-bit SPI frame master.
// Holds the job and result types and the queue and sequencer constants.
package tws_pkg;

   // Operation codes follow the encoding of the mode field.
   typedef enum logic [1:0] {
      OP_CMD   = 2'd0,
      OP_DATA  = 2'd1,
      OP_REGWR = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   // One classified transaction waiting for the back end.
   typedef struct packed {
      op_type     op;
      logic [7:0] cmd_byte;
      logic [7:0] data_low;
      logic [7:0] data_high;
      logic       read_valid;
      logic [7:0] read_byte;
   } job_type;

   // One clock period on the serial side.
   typedef struct packed {
      logic       sdo;
      logic       select_release;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       last;
   } result_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] BIT_LAST   = 4'd8;  // periods 0..8 of a frame
   localparam logic [1:0] FRAME_LAST = 2'd2;  // frames 0..2 of a register write
   localparam logic [2:0] READ_LAST  = 3'd7;  // eighth read bit

   localparam logic DC_COMMAND = 1'b0;
   localparam logic DC_DATA    = 1'b1;

endpackage

// ----- src/tws_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts transactions, classifies them, and assembles read bytes.
// Depends on tws_pkg.
module tws_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [1:0]        req_mode,
   input  logic [7:0]        req_cmd_byte,
   input  logic [7:0]        req_data_low,
   input  logic [7:0]        req_data_high,
   input  logic              req_sdi_bit,
   input  logic              q_full,
   output logic              q_push,
   output tws_pkg::job_type  q_job
);
   import tws_pkg::*;

   logic [7:0] read_shift_ff, read_shift_in;
   logic [2:0] read_count_ff, read_count_in;
   logic [7:0] shifted;
   logic       is_read;
   logic       byte_done;

   assign req_full  = q_full;
   assign q_push    = req_push && !q_full;
   assign is_read   = (op_type'(req_mode) == OP_READ);
   assign shifted   = {read_shift_ff[6:0], req_sdi_bit};
   assign byte_done = (read_count_ff == READ_LAST);

   always_comb begin
      q_job.op         = op_type'(req_mode);
      q_job.cmd_byte   = req_cmd_byte;
      q_job.data_low   = req_data_low;
      q_job.data_high  = req_data_high;
      q_job.read_valid = is_read && byte_done;
      q_job.read_byte  = (is_read && byte_done) ? shifted : 8'd0;
   end

   // Writes leave a partial read byte alone.
   always_comb begin
      read_shift_in = read_shift_ff;
      read_count_in = read_count_ff;
      if (q_push && is_read) begin
         if (byte_done) begin
            read_shift_in = 8'd0;
            read_count_in = 3'd0;
         end else begin
            read_shift_in = shifted;
            read_count_in = read_count_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_shift_ff <= 8'd0;
         read_count_ff <= 3'd0;
      end else begin
         read_shift_ff <= read_shift_in;
         read_count_ff <= read_count_in;
      end
   end

endmodule

// ----- src/tws_queue.sv -----
`timescale 1ns / 1ps
// Short job queue between the front and back ends.
// Depends on tws_pkg for the job type and depth.
module tws_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tws_pkg::job_type  job_in,
   output logic              full,
   input  logic              pop,
   output tws_pkg::job_type  job_out,
   output logic              empty
);
   import tws_pkg::*;

   job_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign job_out = entry_ff[rd_ptr_ff];

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] n;
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/tws_back.sv -----
`timescale 1ns / 1ps
// Back end: serializes queued jobs one bit period per cycle, while results are popped, into an output register.
// Depends on tws_pkg.
module tws_back (
   input  logic              clock,
   input  logic              reset,
   input  tws_pkg::job_type  q_job,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic              rsp_sdo,
   output logic              rsp_select_release,
   output logic              rsp_read_valid,
   output logic [7:0]        rsp_read_byte,
   output logic              rsp_last
);
   import tws_pkg::*;

   logic [3:0]  bit_ff, bit_in;
   logic [1:0]  frame_ff, frame_in;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff, out_in;
   result_type  cur;
   logic        advance;
   logic        last_frame;
   logic        frame_end;
   logic        dc;
   logic [7:0]  frame_byte;
   logic [2:0]  bit_idx;

   assign advance   = !q_empty && (!out_valid_ff || rsp_pop);
   assign bit_idx   = 3'(BIT_LAST - bit_ff);
   assign frame_end = (bit_ff == BIT_LAST);

   // Byte and data/command bit of the frame in progress.
   always_comb begin
      dc         = DC_COMMAND;
      frame_byte = q_job.cmd_byte;
      last_frame = 1'b1;
      case (q_job.op)
         OP_CMD: begin
            dc         = DC_COMMAND;
            frame_byte = q_job.cmd_byte;
         end
         OP_DATA: begin
            dc         = DC_DATA;
            frame_byte = q_job.data_low;
         end
         OP_REGWR: begin
            last_frame = (frame_ff == FRAME_LAST);
            case (frame_ff)
               2'd0: begin
                  dc         = DC_COMMAND;
                  frame_byte = q_job.cmd_byte;
               end
               2'd1: begin
                  dc         = DC_DATA;
                  frame_byte = q_job.data_low;
               end
               default: begin
                  dc         = DC_DATA;
                  frame_byte = q_job.data_high;
               end
            endcase
         end
         default: begin
            dc         = DC_COMMAND;
            frame_byte = 8'd0;
         end
      endcase
   end

   always_comb begin
      if (q_job.op == OP_READ) begin
         cur.sdo            = 1'b0;
         cur.select_release = q_job.read_valid;
         cur.read_valid     = q_job.read_valid;
         cur.read_byte      = q_job.read_byte;
         cur.last           = 1'b1;
      end else begin
         cur.sdo            = (bit_ff == 4'd0) ? dc : frame_byte[bit_idx];
         cur.select_release = last_frame && frame_end;
         cur.read_valid     = 1'b0;
         cur.read_byte      = 8'd0;
         cur.last           = last_frame && frame_end;
      end
   end

   assign q_pop = advance && cur.last;

   always_comb begin
      bit_in       = bit_ff;
      frame_in     = frame_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_in       = cur;
         out_valid_in = 1'b1;
         if (cur.last) begin
            bit_in   = 4'd0;
            frame_in = 2'd0;
         end else if (frame_end) begin
            bit_in   = 4'd0;
            frame_in = frame_ff + 2'd1;
         end else begin
            bit_in = bit_ff + 4'd1;
         end
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff       <= 4'd0;
         frame_ff     <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         bit_ff       <= bit_in;
         frame_ff     <= frame_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty          = !out_valid_ff;
   assign rsp_sdo            = out_ff.sdo;
   assign rsp_select_release = out_ff.select_release;
   assign rsp_read_valid     = out_ff.read_valid;
   assign rsp_read_byte      = out_ff.read_byte;
   assign rsp_last           = out_ff.last;

endmodule

// ----- src/three_wire_spi_frame_master_top.sv -----
`timescale 1ns / 1ps
// Three-wire 9-bit SPI frame master, top level.
// Depends on tws_pkg, tws_front, tws_queue and tws_back.
//
// Each accepted transaction yields one result per serial clock period: a
// command (mode 0) or data (mode 1) frame is a dc bit and a byte, a register
// write (mode 2) is three frames, and a read bit (mode 3) is a single period;
// the eighth read bit returns the assembled byte with select_release set. The
// serializer emits one bit period per cycle while results are popped, so
// sustained throughput is set by the period count of each transaction; a
// 4-deep job queue lets new transactions be accepted while a frame is shifting
// out, and a result register holds the current period until it is popped.
module three_wire_spi_frame_master_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_cmd_byte,
   input  logic [7:0] req_data_low,
   input  logic [7:0] req_data_high,
   input  logic       req_sdi_bit,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_sdo,
   output logic       rsp_select_release,
   output logic       rsp_read_valid,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_last
);
   import tws_pkg::*;

   job_type push_job;
   job_type head_job;
   logic    q_push, q_full, q_pop, q_empty;

   tws_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_mode      (req_mode),
      .req_cmd_byte  (req_cmd_byte),
      .req_data_low  (req_data_low),
      .req_data_high (req_data_high),
      .req_sdi_bit   (req_sdi_bit),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_job         (push_job)
   );

   tws_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .job_in  (push_job),
      .full    (q_full),
      .pop     (q_pop),
      .job_out (head_job),
      .empty   (q_empty)
   );

   tws_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_job              (head_job),
      .q_empty            (q_empty),
      .q_pop              (q_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_sdo            (rsp_sdo),
      .rsp_select_release (rsp_select_release),
      .rsp_read_valid     (rsp_read_valid),
      .rsp_read_byte      (rsp_read_byte),
      .rsp_last           (rsp_last)
   );

   // A completed read byte always closes the chip-select window.
   a_read_closes: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_read_valid) |-> (rsp_select_release && rsp_last))
      else $error("read byte without select release");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_read_valid) |-> (rsp_read_byte == 8'd0))
      else $error("read byte nonzero without read_valid");

   a_release_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_select_release) |-> rsp_last)
      else $error("chip select released before final period");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result pending after reset");

endmodule

// ----- test/three_wire_spi_frame_master_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench for three_wire_spi_frame_master_top: directed frames, writes and reads,
// then random ones. Every serial period is checked against a local frame/read
// predictor. Depends on tws_pkg.
module three_wire_spi_frame_master_top_tb;
   import tws_pkg::*;

   typedef struct packed {
      op_type     mode;
      logic [7:0] cmd_byte;
      logic [7:0] data_low;
      logic [7:0] data_high;
      logic       sdi_bit;
      logic       typed;        // final period below is written out by hand
      result_type final_period;
   } txn_row_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD      = 200;
   localparam int N_DIRECTED     = 24;
   localparam int N_RANDOM       = 346;
   localparam int N_QUIET        = 60;   // last random items, no idling

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [1:0] req_mode = '0;
   logic [7:0] req_cmd_byte = '0;
   logic [7:0] req_data_low = '0;
   logic [7:0] req_data_high = '0;
   logic       req_sdi_bit = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic       rsp_sdo;
   logic       rsp_select_release;
   logic       rsp_read_valid;
   logic [7:0] rsp_read_byte;
   logic       rsp_last;

   three_wire_spi_frame_master_top dut (.*);

   always #4 clock = ~clock;

   // predictor state: partial read byte and bit count
   logic [7:0] read_shift_q = '0;
   logic [2:0] read_count_q = '0;
   result_type expected_periods[$];

   int  error_count = 0;
   int  period_index = 0;
   bit  bursts_on = 1'b1;
   bit  hold_req = 1'b0;
   int  idle_cycles = 0;

   function automatic result_type period(logic sdo, logic rel, logic valid,
                                         logic [7:0] rbyte, logic last);
      result_type p;
      p.sdo = sdo;
      p.select_release = rel;
      p.read_valid = valid;
      p.read_byte = rbyte;
      p.last = last;
      return p;
   endfunction

   function automatic txn_row_type row(op_type mode, logic [7:0] cmd, logic [7:0] lo,
                                       logic [7:0] hi, logic sdi, logic typed,
                                       result_type fin);
      txn_row_type r;
      r.mode = mode;
      r.cmd_byte = cmd;
      r.data_low = lo;
      r.data_high = hi;
      r.sdi_bit = sdi;
      r.typed = typed;
      r.final_period = fin;
      return r;
   endfunction

   // dc bit, then the byte MSB first; chip select is released with the last bit of the last frame
   function void push_frame(logic dc, logic [7:0] b, bit is_final);
      logic ends;
      expected_periods.push_back(period(dc, 1'b0, 1'b0, 8'h00, 1'b0));
      for (int i = 7; i >= 0; i--) begin
         ends = is_final && (i == 0);
         expected_periods.push_back(period(b[i], ends, 1'b0, 8'h00, ends));
      end
   endfunction

   function void predict_periods(txn_row_type t);
      logic [7:0] assembled;
      case (t.mode)
         OP_CMD: begin
            push_frame(DC_COMMAND, t.cmd_byte, 1'b1);
         end
         OP_DATA: begin
            push_frame(DC_DATA, t.data_low, 1'b1);
         end
         OP_REGWR: begin
            push_frame(DC_COMMAND, t.cmd_byte, 1'b0);
            push_frame(DC_DATA, t.data_low, 1'b0);
            push_frame(DC_DATA, t.data_high, 1'b1);
         end
         default: begin
            assembled = {read_shift_q[6:0], t.sdi_bit};
            if (read_count_q == READ_LAST) begin
               expected_periods.push_back(period(1'b0, 1'b1, 1'b1, assembled, 1'b1));
               read_shift_q = '0;
               read_count_q = '0;
            end else begin
               expected_periods.push_back(period(1'b0, 1'b0, 1'b0, 8'h00, 1'b1));
               read_shift_q = assembled;
               read_count_q = read_count_q + 3'd1;
            end
         end
      endcase
   endfunction

   task automatic report_mismatch(string field, int got, int exp);
      $display("period %0d: %s got 0x%0h, expected 0x%0h", period_index, field, got, exp);
      error_count++;
   endtask

   task automatic check_period(result_type got);
      result_type exp;
      if (expected_periods.size() == 0) begin
         report_mismatch("unexpected period, last", got.last, 0);
      end else begin
         exp = expected_periods.pop_front();
         if (got.sdo !== exp.sdo)
            report_mismatch("sdo", got.sdo, exp.sdo);
         if (got.select_release !== exp.select_release)
            report_mismatch("select_release", got.select_release, exp.select_release);
         if (got.read_valid !== exp.read_valid)
            report_mismatch("read_valid", got.read_valid, exp.read_valid);
         if (got.read_byte !== exp.read_byte)
            report_mismatch("read_byte", got.read_byte, exp.read_byte);
         if (got.last !== exp.last)
            report_mismatch("last", got.last, exp.last);
      end
      period_index++;
   endtask

   task automatic send_txn(txn_row_type t);
      if (bursts_on && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_mode      <= t.mode;
      req_cmd_byte  <= t.cmd_byte;
      req_data_low  <= t.data_low;
      req_data_high <= t.data_high;
      req_sdi_bit   <= t.sdi_bit;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_periods(t);
      if (t.typed)
         expected_periods[expected_periods.size() - 1] = t.final_period;
   endtask

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic txn_row_type random_txn();
      op_type m;
      case ($urandom_range(0, 9))
         0, 1: m = OP_CMD;
         2, 3: m = OP_DATA;
         4: m = OP_REGWR;
         default: m = OP_READ;
      endcase
      return row(m, rand_byte(), rand_byte(), rand_byte(), 1'($urandom_range(0, 1)),
                 1'b0, '0);
   endfunction

   // result side: pop with random stall bursts, plus one long hold on request
   initial begin : drain
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty)
            check_period(period(rsp_sdo, rsp_select_release, rsp_read_valid,
                                rsp_read_byte, rsp_last));
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (bursts_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 5);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // ends the run if no transaction moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("three_wire_spi_frame_master_top_tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      txn_row_type directed_rows [N_DIRECTED];
      result_type  bit_wait;
      bit_wait = period(1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
      directed_rows[0]  = row(OP_CMD,   8'h00, 8'h00, 8'h00, 1'b0, 1'b1,
                              period(1'b0, 1'b1, 1'b0, 8'h00, 1'b1));
      directed_rows[1]  = row(OP_CMD,   8'hFF, 8'h00, 8'h00, 1'b0, 1'b1,
                              period(1'b1, 1'b1, 1'b0, 8'h00, 1'b1));
      directed_rows[2]  = row(OP_DATA,  8'h00, 8'h80, 8'hFF, 1'b1, 1'b1,
                              period(1'b0, 1'b1, 1'b0, 8'h00, 1'b1));
      directed_rows[3]  = row(OP_DATA,  8'hFF, 8'h01, 8'h00, 1'b0, 1'b1,
                              period(1'b1, 1'b1, 1'b0, 8'h00, 1'b1));
      directed_rows[4]  = row(OP_REGWR, 8'hA5, 8'h5A, 8'hFF, 1'b0, 1'b1,
                              period(1'b1, 1'b1, 1'b0, 8'h00, 1'b1));
      directed_rows[5]  = row(OP_REGWR, 8'hFF, 8'hFF, 8'h00, 1'b1, 1'b1,
                              period(1'b0, 1'b1, 1'b0, 8'h00, 1'b1));
      // read 0xA5 one bit at a time, unused fields toggled
      directed_rows[6]  = row(OP_READ,  8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1, bit_wait);
      directed_rows[7]  = row(OP_READ,  8'h00, 8'hFF, 8'h00, 1'b0, 1'b1, bit_wait);
      directed_rows[8]  = row(OP_READ,  8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, bit_wait);
      directed_rows[9]  = row(OP_READ,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1, bit_wait);
      directed_rows[10] = row(OP_READ,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1, bit_wait);
      directed_rows[11] = row(OP_READ,  8'h00, 8'h00, 8'h00, 1'b1, 1'b1, bit_wait);
      directed_rows[12] = row(OP_READ,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1, bit_wait);
      directed_rows[13] = row(OP_READ,  8'h00, 8'h00, 8'h00, 1'b1, 1'b1,
                              period(1'b0, 1'b1, 1'b1, 8'hA5, 1'b1));
      // partial read broken up by writes, then finished: 0xFF
      directed_rows[14] = row(OP_READ,  8'h00, 8'h00, 8'h00, 1'b1, 1'b1, bit_wait);
      directed_rows[15] = row(OP_READ,  8'h00, 8'h00, 8'h00, 1'b1, 1'b1, bit_wait);
      directed_rows[16] = row(OP_READ,  8'h00, 8'h00, 8'h00, 1'b1, 1'b1, bit_wait);
      directed_rows[17] = row(OP_CMD,   8'h3C, 8'hC3, 8'h00, 1'b0, 1'b0, '0);
      directed_rows[18] = row(OP_REGWR, 8'h12, 8'h34, 8'h56, 1'b0, 1'b0, '0);
      directed_rows[19] = row(OP_READ,  8'h00, 8'h00, 8'h00, 1'b1, 1'b1, bit_wait);
      directed_rows[20] = row(OP_READ,  8'h00, 8'h00, 8'h00, 1'b1, 1'b1, bit_wait);
      directed_rows[21] = row(OP_READ,  8'h00, 8'h00, 8'h00, 1'b1, 1'b1, bit_wait);
      directed_rows[22] = row(OP_READ,  8'h00, 8'h00, 8'h00, 1'b1, 1'b1, bit_wait);
      directed_rows[23] = row(OP_READ,  8'h00, 8'h00, 8'h00, 1'b1, 1'b1,
                              period(1'b0, 1'b1, 1'b1, 8'hFF, 1'b1));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++)
         send_txn(directed_rows[i]);

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 20)
            hold_req = 1'b1;   // receiver stalls long enough for req_full to rise
         if (i == N_RANDOM - N_QUIET)
            bursts_on = 1'b0;
         send_txn(random_txn());
      end
      req_push <= 1'b0;

      while (expected_periods.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("three_wire_spi_frame_master_top_tb OK");
      else
         $display("three_wire_spi_frame_master_top_tb NOT OK");
      $finish;
   end

endmodule
